### src/itp_pkg.sv
// shared types, constants and operator decoding for the infix to postfix converter
`timescale 1ns / 1ps
package itp_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned MASK_W      = 9;

  localparam logic [7:0] CHAR_OPEN  = 8'h28;  // (
  localparam logic [7:0] CHAR_CLOSE = 8'h29;  // )
  localparam logic [7:0] CHAR_LT    = 8'h3c;  // <
  localparam logic [7:0] CHAR_GT    = 8'h3e;  // >
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;  // +
  localparam logic [7:0] CHAR_MINUS = 8'h2d;  // -
  localparam logic [7:0] CHAR_BAR   = 8'h7c;  // |
  localparam logic [7:0] CHAR_STAR  = 8'h2a;  // *
  localparam logic [7:0] CHAR_SLASH = 8'h2f;  // /
  localparam logic [7:0] CHAR_CARET = 8'h5e;  // ^
  localparam logic [7:0] CHAR_AMP   = 8'h26;  // &

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNMATCHED = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP
  } stk_cmd_e;

  typedef enum logic [1:0] {
    KIND_OP,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_PLAIN
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_CLOSE,
    S_FLUSH,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    err_e       err;
  } res_t;

  // one-hot operator decode, bit order matches the enable mask
  function automatic logic [MASK_W-1:0] op_decode(input logic [7:0] c);
    logic [MASK_W-1:0] hot;
    hot = '0;
    unique case (c)
      CHAR_LT:    hot[0] = 1'b1;
      CHAR_GT:    hot[1] = 1'b1;
      CHAR_PLUS:  hot[2] = 1'b1;
      CHAR_MINUS: hot[3] = 1'b1;
      CHAR_BAR:   hot[4] = 1'b1;
      CHAR_STAR:  hot[5] = 1'b1;
      CHAR_SLASH: hot[6] = 1'b1;
      CHAR_CARET: hot[7] = 1'b1;
      CHAR_AMP:   hot[8] = 1'b1;
      default:    hot = '0;
    endcase
    return hot;
  endfunction

  function automatic logic op_enabled(input logic [7:0] c, input logic [MASK_W-1:0] mask);
    return |(op_decode(c) & mask);
  endfunction

  function automatic logic [1:0] op_prec(input logic [7:0] c);
    logic [MASK_W-1:0] hot;
    logic [1:0]        p;
    hot = op_decode(c);
    if (|hot[8:5]) begin
      p = 2'd3;
    end else if (|hot[4:3]) begin
      p = 2'd2;
    end else if (hot[2]) begin
      p = 2'd1;
    end else begin
      p = 2'd0;
    end
    return p;
  endfunction

  function automatic kind_e classify(input logic [7:0] c, input logic [MASK_W-1:0] mask);
    kind_e k;
    if (op_enabled(c, mask)) begin
      k = KIND_OP;
    end else if (c == CHAR_OPEN) begin
      k = KIND_OPEN;
    end else if (c == CHAR_CLOSE) begin
      k = KIND_CLOSE;
    end else begin
      k = KIND_PLAIN;
    end
    return k;
  endfunction

endpackage

### src/infix_to_postfix_converter_core.sv
// top level: shunting-yard infix to postfix converter with a cell-row operator stack
`timescale 1ns / 1ps
// usage
//   s_axis carries one infix character per request (tdata), tlast ends the expression
//   m_axis returns postfix symbols; tuser flags a character (bit 0) and an error code
//   (bits 2:1), tlast marks the final result of one input request
//   cfg is a write channel for the 9 bit operator enable mask, always ready; write it
//   only while the block is idle
// timing
//   one request at a time; pops run one a cycle through the cell row while results
//   can move on; a last request then flushes the remaining entries
// reset
//   rst_ni is asynchronous active low; it empties the stack, drops pending results
//   and sets the mask to all operators enabled
// stalls
//   results flow through a hold register and an output register; when m_axis_tready
//   is low and both registers are full the converter stops popping, and s_axis_tready
//   stays low until the request's final result has moved into the output register
module infix_to_postfix_converter_core import itp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [MASK_W-1:0] cfg_data_i,     // operator_mask
  // input characters
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] in_char
  input  logic              s_axis_tlast,   // is_last
  // postfix results
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [7:0] out_char
  output logic [2:0]        m_axis_tuser,   // [0] has_char, [2:1] error_code
  output logic              m_axis_tlast    // last
);

  // config register
  logic [MASK_W-1:0] mask_q;

  // current request
  logic [7:0] char_q;
  logic       last_q;
  kind_e      kind_q;

  state_e state_q, state_d;

  // stack signals
  stk_cmd_e         stk_cmd, stk_cmd_req;
  logic [7:0]       stk_top;
  logic [CNT_W-1:0] stk_count;
  logic             stk_empty, stk_full, can_pop;

  // result path
  logic hold_valid_q, out_valid_q, out_last_q;
  res_t hold_q, out_q, res_new;
  logic out_free, emit_ok, emit_req, emit_fire, step_go, fin, finish_move, finish_done;
  logic out_load, s_accept;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mask_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      char_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
      kind_q <= classify(s_axis_tdata, mask_q);
    end
  end

  assign stk_empty = (stk_count == '0);
  assign stk_full  = (stk_count == CNT_W'(STACK_DEPTH));
  // precedence pop stops at '(' and at operators disabled since they were stacked
  assign can_pop   = !stk_empty && op_enabled(stk_top, mask_q) &&
                     (op_prec(stk_top) >= op_prec(char_q));

  // a new result may be produced when the hold register is empty or can move on
  assign out_free = !out_valid_q || m_axis_tready;
  assign emit_ok  = !hold_valid_q || out_free;

  // per-state actions
  always_comb begin
    stk_cmd_req = STK_HOLD;
    emit_req    = 1'b0;
    res_new     = '{ch: 8'h00, has_char: 1'b0, err: ERR_NONE};
    fin         = 1'b0;
    unique case (state_q)
      S_OP: begin
        if (kind_q == KIND_PLAIN) begin
          emit_req = 1'b1;
          res_new  = '{ch: char_q, has_char: 1'b1, err: ERR_NONE};
          fin      = 1'b1;
        end else if (kind_q == KIND_OP && can_pop) begin
          emit_req    = 1'b1;
          res_new     = '{ch: stk_top, has_char: 1'b1, err: ERR_NONE};
          stk_cmd_req = STK_POP;
        end else if (stk_full) begin
          // push onto a full stack drops the character
          emit_req = 1'b1;
          res_new  = '{ch: 8'h00, has_char: 1'b0, err: ERR_OVERFLOW};
          fin      = 1'b1;
        end else begin
          stk_cmd_req = STK_PUSH;
          fin         = 1'b1;
        end
      end
      S_CLOSE: begin
        if (!stk_empty && stk_top != CHAR_OPEN) begin
          emit_req    = 1'b1;
          res_new     = '{ch: stk_top, has_char: 1'b1, err: ERR_NONE};
          stk_cmd_req = STK_POP;
        end else if (!stk_empty) begin
          // matching opening parenthesis is discarded
          stk_cmd_req = STK_POP;
          fin         = 1'b1;
        end else begin
          emit_req = 1'b1;
          res_new  = '{ch: 8'h00, has_char: 1'b0, err: ERR_UNMATCHED};
          fin      = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!stk_empty) begin
          emit_req    = 1'b1;
          res_new     = '{ch: stk_top, has_char: 1'b1, err: ERR_NONE};
          stk_cmd_req = STK_POP;
        end else begin
          fin = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign step_go     = !emit_req || emit_ok;
  assign emit_fire   = emit_req && emit_ok;
  assign stk_cmd     = step_go ? stk_cmd_req : STK_HOLD;
  // the held result is the request's final one once the work is done
  assign finish_move = (state_q == S_FINISH) && hold_valid_q && out_free;
  assign finish_done = !hold_valid_q || out_free;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          state_d = (classify(s_axis_tdata, mask_q) == KIND_CLOSE) ? S_CLOSE : S_OP;
        end
      end
      S_OP, S_CLOSE: begin
        if (step_go && fin) begin
          state_d = last_q ? S_FLUSH : S_FINISH;
        end
      end
      S_FLUSH: begin
        if (fin) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (finish_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  itp_stack u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (stk_cmd),
    .push_data_i (char_q),
    .top_o       (stk_top),
    .count_o     (stk_count)
  );

  // hold register delays each result until its last flag is known
  assign out_load = (emit_fire && hold_valid_q) || finish_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (emit_fire) begin
        hold_valid_q <= 1'b1;
      end else if (finish_move) begin
        hold_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      hold_q <= res_new;
    end
    if (out_load) begin
      out_q      <= hold_q;
      out_last_q <= finish_move;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.ch;
  assign m_axis_tuser  = {out_q.err, out_q.has_char};
  assign m_axis_tlast  = out_last_q;

  // checks
  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !hold_valid_q)
    else $error("result held while idle");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> state_q != S_IDLE)
    else $error("request accepted without work");

  a_char_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] == ERR_NONE)
    else $error("character result carries an error");

endmodule

### src/itp_cell.sv
// one stack cell: holds an entry and shifts toward or away from the top
`timescale 1ns / 1ps
module itp_cell import itp_pkg::*; (
  input  logic       clk_i,
  input  stk_cmd_e   cmd_i,
  input  logic [7:0] up_i,    // neighbor nearer the top (or new entry)
  input  logic [7:0] down_i,  // neighbor farther from the top
  output logic [7:0] data_o
);

  logic [7:0] data_q, data_d;

  always_comb begin
    unique case (cmd_i)
      STK_PUSH: data_d = up_i;
      STK_POP:  data_d = down_i;
      default:  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### src/itp_stack.sv
// operator stack built as a row of shifting cells with an entry count
`timescale 1ns / 1ps
module itp_stack import itp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stk_cmd_e         cmd_i,
  input  logic [7:0]       push_data_i,
  output logic [7:0]       top_o,
  output logic [CNT_W-1:0] count_o
);

  logic [7:0]       cell_data [STACK_DEPTH];
  logic [CNT_W-1:0] count_q, count_d;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [7:0] up, down;
    if (i == 0) begin : g_top
      assign up = push_data_i;
    end else begin : g_mid
      assign up = cell_data[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign down = cell_data[i];
    end else begin : g_low
      assign down = cell_data[i+1];
    end
    itp_cell u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd_i),
      .up_i   (up),
      .down_i (down),
      .data_o (cell_data[i])
    );
  end

  always_comb begin
    unique case (cmd_i)
      STK_PUSH: count_d = count_q + CNT_W'(1);
      STK_POP:  count_d = count_q - CNT_W'(1);
      default:  count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign top_o   = cell_data[0];
  assign count_o = count_q;

endmodule
